// ===== rtl/sai_pkg.sv =====
package sai_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CFG_BITS       = 8;
  localparam int OP_BITS        = 2;
  localparam int STATUS_BITS    = 2;

  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REFILL = 2'd2;

  localparam logic [STATUS_BITS-1:0] STAT_DONE     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DELETE,
    ACT_REFILL
  } act_t;

  typedef struct packed {
    logic cmp;
    logic incl_eq;
    act_t act;
  } cell_ctl_t;

endpackage

// ===== rtl/sai_cell.sv =====
module sai_cell #(
  parameter int VALUE_BITS = sai_pkg::VALUE_BITS_DEF,
  parameter int CW         = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  sai_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0] operand,
  input  logic [CW-1:0]         count,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_pre,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  pre,
  output logic                  eq
);

  localparam logic [CW-1:0]         IdxC      = CW'(IDX);
  localparam logic [VALUE_BITS-1:0] RefillVal = VALUE_BITS'(IDX + 1);

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  pre_r, eq_r;
  logic                  valid;
  logic                  pre_nxt;

  assign valid = IdxC < count;

  always_comb begin
    if (ctl.incl_eq) begin
      pre_nxt = valid && ($signed(val_r) <= $signed(operand));
    end else begin
      pre_nxt = valid && ($signed(val_r) < $signed(operand));
    end
  end

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.act)
      sai_pkg::ACT_HOLD: begin
        val_nxt = val_r;
      end
      sai_pkg::ACT_INSERT: begin
        if (!pre_r) begin
          val_nxt = left_pre ? operand : left_val;
        end
      end
      sai_pkg::ACT_DELETE: begin
        if (!pre_r) begin
          val_nxt = right_val;
        end
      end
      sai_pkg::ACT_REFILL: begin
        val_nxt = RefillVal;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctl.cmp) begin
      pre_r <= pre_nxt;
      eq_r  <= valid && (val_r == operand);
    end
  end

  assign val = val_r;
  assign pre = pre_r;
  assign eq  = eq_r;

endmodule

// ===== rtl/sorted_array_insert_delete.sv =====
// Sorted array of signed values kept in a row of cells, one entry per cell. A request
// is taken when start is high and busy is low. busy then stays high through the
// compare and apply steps, and the result strobe out_valid comes from the output
// register. In the compare step every cell compares its entry with the operand; in
// the apply step the row shifts by one place and the position is encoded. out_valid
// is high for exactly one cycle and the receiver cannot hold it off; a new request
// may be issued in that same cycle. Entries have no reset and no clearing pass:
// only entries below the fill count are ever read. The user must write
// cfg_initial_count only while busy is low; the block itself does not enforce this.
module sorted_array_insert_delete #(
  parameter int DEPTH      = sai_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sai_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sai_pkg::OP_BITS-1:0]     in_operation,
  input  logic signed [VALUE_BITS-1:0]    in_value,
  input  logic                            cfg_write_en,
  input  logic [sai_pkg::CFG_BITS-1:0]    cfg_initial_count,
  output logic                            out_valid,
  output logic [sai_pkg::STATUS_BITS-1:0] out_status,
  output logic [$clog2(DEPTH)-1:0]        out_position,
  output logic [$clog2(DEPTH+1)-1:0]      out_count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sai_pkg::state_t                 state_r, state_nxt;
  logic [sai_pkg::OP_BITS-1:0]     op_r, op_nxt;
  logic [VALUE_BITS-1:0]           operand_r, operand_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [sai_pkg::CFG_BITS-1:0]    init_r, init_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sai_pkg::STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [PW-1:0]                   out_position_r, out_position_nxt;
  logic [CW-1:0]                   out_count_r, out_count_nxt;

  sai_pkg::cell_ctl_t    ctl;
  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]      pre_v;
  logic [DEPTH-1:0]      eq_v;
  logic [DEPTH-1:0]      bnd_v;
  logic [PW-1:0]         pos_enc;
  logic                  found;
  logic                  full;
  logic [CW-1:0]         refill_n;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lv;
    logic                  lp;
    logic [VALUE_BITS-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lp = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lp = pre_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end
    sai_cell #(
      .VALUE_BITS(VALUE_BITS),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .operand  (operand_r),
      .count    (count_r),
      .left_val (lv),
      .left_pre (lp),
      .right_val(rv),
      .val      (cell_val[i]),
      .pre      (pre_v[i]),
      .eq       (eq_v[i])
    );
  end

  // first cell past the prefix of smaller entries (smaller or equal for an insert)
  assign bnd_v = ~pre_v & {pre_v[DEPTH-2:0], 1'b1};
  assign found = |eq_v;
  assign full  = count_r == CW'(DEPTH);

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bnd_v[i]) begin
        pos_enc = pos_enc | PW'(i);
      end
    end
  end

  always_comb begin
    if (32'(init_r) > 32'(DEPTH)) begin
      refill_n = CW'(DEPTH);
    end else begin
      refill_n = CW'(init_r);
    end
  end

  assign init_nxt = cfg_write_en ? cfg_initial_count : init_r;

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    operand_nxt      = operand_r;
    count_nxt        = count_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    out_count_nxt    = out_count_r;
    ctl.cmp          = 1'b0;
    ctl.incl_eq      = op_r == sai_pkg::OP_INSERT;
    ctl.act          = sai_pkg::ACT_HOLD;
    unique case (state_r)
      sai_pkg::S_IDLE: begin
        if (start) begin
          op_nxt      = in_operation;
          operand_nxt = in_value;
          state_nxt   = sai_pkg::S_CMP;
        end
      end
      sai_pkg::S_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = sai_pkg::S_APPLY;
      end
      sai_pkg::S_APPLY: begin
        state_nxt        = sai_pkg::S_IDLE;
        out_valid_nxt    = 1'b1;
        out_status_nxt   = sai_pkg::STAT_DONE;
        out_position_nxt = '0;
        case (op_r)
          sai_pkg::OP_INSERT: begin
            if (full) begin
              out_status_nxt = sai_pkg::STAT_FULL;
            end else begin
              ctl.act          = sai_pkg::ACT_INSERT;
              out_position_nxt = pos_enc;
              count_nxt        = count_r + CW'(1);
            end
          end
          sai_pkg::OP_DELETE: begin
            if (!found) begin
              out_status_nxt = sai_pkg::STAT_NOTFOUND;
            end else begin
              ctl.act          = sai_pkg::ACT_DELETE;
              out_position_nxt = pos_enc;
              count_nxt        = count_r - CW'(1);
            end
          end
          sai_pkg::OP_REFILL: begin
            ctl.act   = sai_pkg::ACT_REFILL;
            count_nxt = refill_n;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
        out_count_nxt = count_nxt;
      end
      default: begin
        state_nxt = sai_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sai_pkg::S_IDLE;
      count_r     <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    operand_r      <= operand_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign busy         = state_r != sai_pkg::S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("request without result");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == sai_pkg::S_APPLY))
    else $error("result strobe outside apply");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sai_pkg::S_APPLY) |-> $onehot0(bnd_v))
    else $error("compare flags not a prefix");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 !busy)
    else $error("busy window wrong");

endmodule
